// ===== hw/rtl/hough_line_sort_merge_defines.svh =====
// Assertion macros used by the Hough line sort-merge top level.
`ifndef HOUGH_LINE_SORT_MERGE_DEFINES_SVH
`define HOUGH_LINE_SORT_MERGE_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define HLSM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
// antecedent in one cycle implies consequent in the next
`define HLSM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define HLSM_ASSERT(name, clk, rst, prop)
`define HLSM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/hlsm_pkg.sv =====
// Shared types and constants for the Hough line sort-merge block.
package hlsm_pkg;

   localparam int MaxLines   = 64;
   localparam int CountWidth = $clog2(MaxLines + 1);
   localparam int DistWidth  = 16;
   localparam int AngleWidth = 15;

   // register reset values (Q2.13 radians)
   localparam logic [AngleWidth-1:0] TolReset      = 15'd1638;
   localparam logic [AngleWidth-1:0] SkipLowReset  = 15'd12288;
   localparam logic [AngleWidth-1:0] SkipHighReset = 15'd13517;

   // register indexes
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CsrMergeTol  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSkipLow   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrSkipHigh  = 2'd2;

   typedef struct packed {
      logic signed [DistWidth-1:0] distance;
      logic [AngleWidth-1:0]       angle;
   } line_type;

   // per-cycle command broadcast along the cell chain
   typedef struct packed {
      logic insert;  // load a new line in sorted position
      logic shift;   // move every line one cell toward the head
   } cell_ctl_type;

   typedef struct packed {
      logic [AngleWidth-1:0] merge_tol;
      logic [AngleWidth-1:0] skip_low;
      logic [AngleWidth-1:0] skip_high;
   } csr_type;

endpackage

// ===== hw/rtl/hough_line_sort_merge.sv =====
// Top level: loads lines into a sorted cell chain, then walks and merges them.
// Load: one line per cycle, inserted in rho order by a 64-cell insertion chain.
// Walk: starts the cycle after the final line; one sorted line per cycle while the
//   result side takes results; the first result passes the walk state register and
//   then the output register.
// No line is taken during the walk; the next set may start the cycle after it.
// Synchronous active-high reset empties the chain and loads register defaults.
`include "hough_line_sort_merge_defines.svh"

module hough_line_sort_merge (
   input  logic        clock,
   input  logic        reset,
   // line_distance[15:0], line_angle[30:16], zero [31]
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // merged_distance[15:0], merged_angle[30:16], zero [31]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tuser,   // keep_line
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [hlsm_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [hlsm_pkg::AngleWidth-1:0]    csr_data
);

   localparam int N  = hlsm_pkg::MaxLines;
   localparam int CW = hlsm_pkg::CountWidth;
   localparam int DW = hlsm_pkg::DistWidth;
   localparam int AW = hlsm_pkg::AngleWidth;

   localparam logic StLoad = 1'b0;
   localparam logic StWalk = 1'b1;

   logic                state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   hlsm_pkg::csr_type   csr_ff, csr_in;

   logic                req_accept;
   logic                do_insert;
   logic                walk_step;
   logic                last_line;
   hlsm_pkg::line_type  new_line;
   hlsm_pkg::cell_ctl_type ctl;
   hlsm_pkg::line_type  cell_line [N];
   logic                cell_keep [N];
   hlsm_pkg::line_type  out_line;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == StLoad);
   assign req_accept = req_tvalid && req_tready;
   assign do_insert  = req_accept && (count_ff < CW'(N));

   assign new_line.distance = req_tdata[DW-1:0];
   assign new_line.angle    = req_tdata[DW+AW-1:DW];

   assign ctl.insert = do_insert;
   assign ctl.shift  = walk_step;

   // configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            hlsm_pkg::CsrMergeTol: csr_in.merge_tol = csr_data;
            hlsm_pkg::CsrSkipLow:  csr_in.skip_low  = csr_data;
            hlsm_pkg::CsrSkipHigh: csr_in.skip_high = csr_data;
            default:               csr_in = csr_ff;
         endcase
      end
   end

   // load / walk sequencing and line count
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         StLoad: begin
            if (do_insert) begin
               count_in = count_ff + CW'(1);
            end
            if (req_accept && req_tlast) begin
               state_in = StWalk;
            end
         end
         StWalk: begin
            if (walk_step) begin
               count_in = count_ff - CW'(1);
               if (last_line) begin
                  state_in = StLoad;
               end
            end
         end
         default: state_in = StLoad;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= StLoad;
         count_ff         <= '0;
         csr_ff.merge_tol <= hlsm_pkg::TolReset;
         csr_ff.skip_low  <= hlsm_pkg::SkipLowReset;
         csr_ff.skip_high <= hlsm_pkg::SkipHighReset;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         csr_ff   <= csr_in;
      end
   end

   // insertion chain, head at cell 0
   for (genvar i = 0; i < N; i++) begin : g_cell
      hlsm_pkg::line_type prev_line;
      hlsm_pkg::line_type next_line;
      logic               prev_keep;
      logic               occupied;

      assign occupied = (CW'(i) < count_ff);
      if (i == 0) begin : g_head
         assign prev_line = new_line;
         assign prev_keep = 1'b1;
      end else begin : g_body
         assign prev_line = cell_line[i-1];
         assign prev_keep = cell_keep[i-1];
      end
      if (i == N - 1) begin : g_tail
         assign next_line = '0;
      end else begin : g_mid
         assign next_line = cell_line[i+1];
      end

      hlsm_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .new_line  (new_line),
         .prev_line (prev_line),
         .prev_keep (prev_keep),
         .next_line (next_line),
         .occupied  (occupied),
         .line_out  (cell_line[i]),
         .keep_out  (cell_keep[i])
      );
   end

   assign last_line = (count_ff == CW'(1));

   hlsm_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .active     (state_ff == StWalk),
      .head_line  (cell_line[0]),
      .next_angle (cell_line[1].angle),
      .last_line  (last_line),
      .csr        (csr_ff),
      .step       (walk_step),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_line   (out_line),
      .out_keep   (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_line.angle, out_line.distance};

   `HLSM_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(N))
   `HLSM_ASSERT(a_walk_nonempty, clock, reset, (state_ff != StWalk) || (count_ff != '0))
   `HLSM_ASSERT(a_step_in_walk, clock, reset, !walk_step || (state_ff == StWalk))
   `HLSM_ASSERT_NEXT(a_final_starts_walk, clock, reset, req_accept && req_tlast, state_ff == StWalk)
   `HLSM_ASSERT_NEXT(a_last_ends_set, clock, reset, walk_step && last_line, (state_ff == StLoad) && (count_ff == '0) && rsp_tvalid && rsp_tlast)

endmodule

// ===== hw/rtl/hlsm_cell.sv =====
// One slot of the insertion sort chain: holds a line, inserts or shifts.
module hlsm_cell (
   input  logic                  clock,
   input  hlsm_pkg::cell_ctl_type ctl,
   input  hlsm_pkg::line_type    new_line,
   input  hlsm_pkg::line_type    prev_line,
   input  logic                  prev_keep,
   input  hlsm_pkg::line_type    next_line,
   input  logic                  occupied,
   output hlsm_pkg::line_type    line_out,
   output logic                  keep_out
);

   hlsm_pkg::line_type line_ff;
   hlsm_pkg::line_type line_in;

   // an occupied slot whose rho is not below the new one stays put (ties keep order)
   assign keep_out = occupied && ($signed(line_ff.distance) >= $signed(new_line.distance));

   always_comb begin
      line_in = line_ff;
      if (ctl.insert) begin
         if (!keep_out) begin
            line_in = prev_keep ? new_line : prev_line;
         end
      end else if (ctl.shift) begin
         line_in = next_line;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

   assign line_out = line_ff;

endmodule

// ===== hw/rtl/hlsm_walk.sv =====
// Merge sequencer: walks the sorted head, keeps the running average, drives results.
module hlsm_walk (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 active,
   input  hlsm_pkg::line_type   head_line,
   input  logic [hlsm_pkg::AngleWidth-1:0] next_angle,
   input  logic                 last_line,
   input  hlsm_pkg::csr_type    csr,
   output logic                 step,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hlsm_pkg::line_type   out_line,
   output logic                 out_keep,
   output logic                 out_last
);

   localparam int AW = hlsm_pkg::AngleWidth;
   localparam int DW = hlsm_pkg::DistWidth;

   logic signed [DW-1:0] run_distance_ff, run_distance_in;
   logic [AW-1:0]        run_angle_ff, run_angle_in;
   logic                 out_valid_ff, out_valid_in;
   hlsm_pkg::line_type   out_line_ff, out_line_in;
   logic                 out_keep_ff, out_keep_in;
   logic                 out_last_ff, out_last_in;

   logic [AW-1:0]        angle_diff;
   logic                 close;
   logic                 run_open;
   logic [AW:0]          angle_sum;
   logic signed [DW:0]   dist_sum;
   logic signed [DW:0]   dist_adj;
   hlsm_pkg::line_type   avg_line;
   hlsm_pkg::line_type   run_line;
   hlsm_pkg::line_type   emit_line;
   logic                 emit;

   // during the walk, advance one line whenever the output register can take a result
   assign step = active && (!out_valid_ff || out_ready);

   assign angle_diff = (head_line.angle > next_angle) ? (head_line.angle - next_angle)
                                                      : (next_angle - head_line.angle);
   assign close      = !last_line && (angle_diff < csr.merge_tol);
   assign run_open   = (run_angle_ff != '0);

   // pair average: theta floors, rho truncates toward zero
   assign angle_sum = {1'b0, run_angle_ff} + {1'b0, head_line.angle};
   assign dist_sum  = {run_distance_ff[DW-1], run_distance_ff}
                    + {head_line.distance[DW-1], head_line.distance};
   assign dist_adj  = dist_sum + {{DW{1'b0}}, dist_sum[DW]};
   assign avg_line.distance = dist_adj[DW:1];
   assign avg_line.angle    = angle_sum[AW:1];
   assign run_line.distance = run_distance_ff;
   assign run_line.angle    = run_angle_ff;

   always_comb begin
      run_distance_in = run_distance_ff;
      run_angle_in    = run_angle_ff;
      emit            = 1'b0;
      emit_line       = head_line;
      if (step) begin
         if (last_line) begin
            emit            = 1'b1;
            emit_line       = run_open ? avg_line : head_line;
            run_distance_in = '0;
            run_angle_in    = '0;
         end else if (close) begin
            run_distance_in = run_open ? avg_line.distance : head_line.distance;
            run_angle_in    = run_open ? avg_line.angle : head_line.angle;
         end else begin
            emit            = 1'b1;
            emit_line       = run_open ? run_line : head_line;
            run_distance_in = '0;
            run_angle_in    = '0;
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff && !out_ready;
      out_line_in  = out_line_ff;
      out_keep_in  = out_keep_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_line_in  = emit_line;
         out_keep_in  = !((emit_line.angle > csr.skip_low) && (emit_line.angle < csr.skip_high));
         out_last_in  = last_line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_distance_ff <= '0;
         run_angle_ff    <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         run_distance_ff <= run_distance_in;
         run_angle_ff    <= run_angle_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_line_ff <= out_line_in;
      out_keep_ff <= out_keep_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_line  = out_line_ff;
   assign out_keep  = out_keep_ff;
   assign out_last  = out_last_ff;

endmodule

// ===== test/hlsm_merge_checker.sv =====
// Checker for the Hough line sort-merge block: watches all channels, predicts and compares.
module hlsm_merge_checker
   import hlsm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [31:0]              req_tdata,
   input  logic                     req_tlast,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [31:0]              rsp_tdata,
   input  logic                     rsp_tuser,
   input  logic                     rsp_tlast,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [AngleWidth-1:0]    csr_data,
   output int                       mismatches,
   output int                       lines_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [DistWidth-1:0] distance;
      logic [AngleWidth-1:0]       angle;
      logic                        keep;
      logic                        last;
   } merged_line_type;

   line_type        sorted_lines [MaxLines];
   int              loaded;
   csr_type         regs;
   merged_line_type merged_q [$];
   int              fail_total = 0;

   // keep is cleared only strictly inside the skip band
   function automatic logic keep_for(input logic [AngleWidth-1:0] angle);
      return !(angle > regs.skip_low && angle < regs.skip_high);
   endfunction

   // insertion into the rho-descending table; equal rho stays behind earlier lines
   task automatic load_line(input line_type ln);
      int pos;
      pos = loaded;
      if (loaded >= MaxLines) return;
      while (pos > 0 && $signed(sorted_lines[pos-1].distance) < $signed(ln.distance)) begin
         sorted_lines[pos] = sorted_lines[pos-1];
         pos--;
      end
      sorted_lines[pos] = ln;
      loaded++;
   endtask

   task automatic push_merged(input int rho, input int angle, input logic last);
      merged_line_type m;
      m.distance = rho[DistWidth-1:0];
      m.angle    = angle[AngleWidth-1:0];
      m.keep     = keep_for(m.angle);
      m.last     = last;
      merged_q.push_back(m);
   endtask

   // walk the sorted table, folding close neighbors into a pair average
   task automatic merge_set();
      int run_dist;
      int run_ang;
      int cur_dist;
      int cur_ang;
      int next_ang;
      int gap;
      run_dist = 0;
      run_ang  = 0;
      for (int i = 0; i < loaded; i++) begin
         cur_dist = int'(sorted_lines[i].distance);
         cur_ang  = int'(sorted_lines[i].angle);
         if (i == loaded - 1) begin
            // the last line always produces the final result of the set
            if (run_ang == 0) begin
               push_merged(cur_dist, cur_ang, 1'b1);
            end else begin
               run_ang  = (run_ang + cur_ang) >> 1;
               run_dist = (run_dist + cur_dist) / 2;
               push_merged(run_dist, run_ang, 1'b1);
            end
         end else begin
            next_ang = int'(sorted_lines[i+1].angle);
            gap = (cur_ang > next_ang) ? cur_ang - next_ang : next_ang - cur_ang;
            if (gap < int'(regs.merge_tol)) begin
               // a zero run angle counts as no open run
               if (run_ang == 0) begin
                  run_ang  = cur_ang;
                  run_dist = cur_dist;
               end else begin
                  run_ang  = (run_ang + cur_ang) >> 1;
                  run_dist = (run_dist + cur_dist) / 2;
               end
            end else begin
               if (run_ang != 0) begin
                  push_merged(run_dist, run_ang, 1'b0);
               end else begin
                  push_merged(cur_dist, cur_ang, 1'b0);
               end
               run_ang  = 0;
               run_dist = 0;
            end
         end
      end
      loaded = 0;
   endtask

   always @(posedge clock) begin : watch
      line_type        ln;
      merged_line_type want;
      if (reset) begin
         loaded = 0;
         regs   = '{merge_tol: TolReset, skip_low: SkipLowReset, skip_high: SkipHighReset};
         merged_q.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrMergeTol: regs.merge_tol = csr_data;
               CsrSkipLow:  regs.skip_low  = csr_data;
               CsrSkipHigh: regs.skip_high = csr_data;
               default: ;
            endcase
         end
         // line requests; the marked one starts the walk even when dropped
         if (req_tvalid && req_tready) begin
            ln.distance = req_tdata[DistWidth-1:0];
            ln.angle    = req_tdata[DistWidth+AngleWidth-1:DistWidth];
            load_line(ln);
            if (req_tlast) merge_set();
         end
         // merged lines out
         if (rsp_tvalid && rsp_tready) begin
            if (merged_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("unexpected merged line: rho %0d theta %0d keep %b last %b",
                           $signed(rsp_tdata[15:0]), rsp_tdata[30:16], rsp_tuser, rsp_tlast);
            end else begin
               want = merged_q.pop_front();
               if (rsp_tdata !== {1'b0, want.angle, want.distance} || rsp_tuser !== want.keep
                   || rsp_tlast !== want.last) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display({"merged line mismatch: expected rho %0d theta %0d keep %b last %b,",
                               " got rho %0d theta %0d pad %b keep %b last %b"},
                              want.distance, want.angle, want.keep, want.last,
                              $signed(rsp_tdata[15:0]), rsp_tdata[30:16], rsp_tdata[31],
                              rsp_tuser, rsp_tlast);
               end
            end
         end
      end
      mismatches    <= fail_total;
      lines_pending <= merged_q.size();
   end

endmodule

// ===== test/tb_hough_line_sort_merge.sv =====
// Testbench top for the Hough line sort-merge block: clock, reset, line sets and verdict.
module tb_hough_line_sort_merge;
   import hlsm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 200000;
   localparam int PhaseItems = 20;
   localparam logic [AngleWidth-1:0]    AngleMax = 15'd25736;
   localparam logic [CsrIndexWidth-1:0] CsrSpare = 2'd3;  // no register behind this index

   logic                     clock;
   logic                     reset      = 1'b1;
   logic [31:0]              req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [31:0]              rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index  = '0;
   logic [AngleWidth-1:0]    csr_data   = '0;

   logic calm = 1'b0;  // no idling on either side while set
   int   lines_sent = 0;
   int   cycles = 0;
   int   mismatches;
   int   lines_pending;

   hough_line_sort_merge i_dut (.*);

   hlsm_merge_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side stalls at random
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 21);
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("tb_hough_line_sort_merge: done, errors");
         $finish;
      end
   end

   // one line request, with random gaps ahead of it
   task automatic send_line(input logic signed [DistWidth-1:0] rho,
                            input logic [AngleWidth-1:0] angle, input logic last);
      while (!calm && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, angle, rho};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lines_sent++;
   endtask

   // hold off until every merged line is back and the block has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (lines_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [AngleWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [AngleWidth-1:0] tol, input logic [AngleWidth-1:0] low,
                           input logic [AngleWidth-1:0] high);
      write_csr(CsrMergeTol, tol);
      write_csr(CsrSkipLow, low);
      write_csr(CsrSkipHigh, high);
   endtask

   // a set whose angles mostly cluster around one base so that neighbors merge
   task automatic send_random_set(input int count);
      logic [AngleWidth-1:0]       base;
      logic [AngleWidth-1:0]       angle;
      logic signed [DistWidth-1:0] rho;
      base = ($urandom_range(0, 3) == 0) ? AngleWidth'($urandom)
                                         : AngleWidth'($urandom_range(0, AngleMax));
      rho  = DistWidth'($urandom);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 4))
            0: rho = DistWidth'($urandom);
            1: rho = DistWidth'($urandom_range(0, 4) - 2);
            2: ;  // same rho as the previous line
            default: rho = DistWidth'($urandom_range(0, 2047) - 1024);
         endcase
         case ($urandom_range(0, 5))
            0: angle = AngleWidth'($urandom);
            1: angle = '0;
            2: angle = base;
            default: angle = AngleWidth'(base + $urandom_range(0, 3000) - 1500);
         endcase
         send_line(rho, angle, i == count - 1);
      end
   endtask

   // mostly short sets, now and then a long one
   task automatic run_phase(input int budget);
      int start;
      int count;
      start = lines_sent;
      while (lines_sent - start < budget) begin
         case ($urandom_range(0, 9))
            0: count = 1;
            8: count = $urandom_range(11, 40);
            9: count = $urandom_range(41, MaxLines);
            default: count = $urandom_range(2, 10);
         endcase
         send_random_set(count);
         if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // lone line at the top rho and zero angle
      send_line(16'sh7fff, '0, 1'b1);
      // lowest rho, all-ones angle, band edges, rho ties, negative averaging,
      // and a run that starts on a zero angle
      send_line(16'sh8000, AngleMax, 1'b0);
      send_line(16'sh0000, 15'h7fff, 1'b0);
      send_line(16'sd100, 15'd12288, 1'b0);
      send_line(16'sd100, 15'd12289, 1'b0);
      send_line(16'sd100, 15'd13516, 1'b0);
      send_line(16'sd100, 15'd13517, 1'b0);
      send_line(-16'sd3, 15'd5000, 1'b0);
      send_line(-16'sd4, 15'd5001, 1'b0);
      send_line(-16'sd4, 15'd5003, 1'b0);
      send_line(16'sd50, 15'd0, 1'b0);
      send_line(16'sd49, 15'd100, 1'b0);
      send_line(16'sd48, 15'd200, 1'b1);
      // alternating bit patterns
      send_line(16'sh5555, 15'h2aaa, 1'b0);
      send_line(16'shaaaa, 15'h5555, 1'b1);
      drain();

      // nothing merges, empty skip band, no idling
      calm <= 1'b1;
      set_regs('0, '0, '0);
      run_phase(PhaseItems);
      calm <= 1'b0;

      // everything merges, widest skip band; spare index must be ignored
      set_regs(15'h7fff, '0, 15'h7fff);
      write_csr(CsrSpare, AngleWidth'($urandom));
      run_phase(PhaseItems);

      // upper extremes, with one set that overflows the table
      set_regs(AngleMax, AngleMax, AngleMax);
      send_random_set(MaxLines + $urandom_range(1, 5));
      drain();
      run_phase(PhaseItems);

      set_regs(AngleWidth'($urandom_range(0, 4096)), AngleWidth'($urandom),
               AngleWidth'($urandom));
      run_phase(PhaseItems);

      set_regs(TolReset, SkipLowReset, SkipHighReset);
      run_phase(PhaseItems);

      drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && lines_pending == 0) begin
         $display("tb_hough_line_sort_merge: done, clean");
      end else begin
         $display("tb_hough_line_sort_merge: done, errors");
      end
      $finish;
   end

endmodule

// ===== hough_line_sort_merge.f =====
+incdir+hw/rtl
hw/rtl/hlsm_pkg.sv
hw/rtl/hlsm_cell.sv
hw/rtl/hlsm_walk.sv
hw/rtl/hough_line_sort_merge.sv
test/hlsm_merge_checker.sv
test/tb_hough_line_sort_merge.sv
